@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, character codes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Screen geometry
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   // Item field widths
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   // Blank cell: space, attribute zero (attribute in the high byte)
   localparam logic [CELL_W-1:0] BLANK_CELL = {8'd0, CH_SPACE};

   // Opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_PUT,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK,
      ST_DONE
   } state_type;

endpackage

@@ sv/tcw_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console request channel
// Valid/ready channel carrying one console operation item.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                              valid;
   logic                              ready;
   logic [tcw_pkg::OP_W-1:0]          opcode;
   logic [tcw_pkg::CHAR_W-1:0]        char_code;
   logic [tcw_pkg::COLOR_W-1:0]       fg_colour;
   logic [tcw_pkg::COLOR_W-1:0]       bg_colour;
   logic [tcw_pkg::COL_W-1:0]         read_col;
   logic [tcw_pkg::ROW_W-1:0]         read_row;

   modport source (output valid, opcode, char_code, fg_colour, bg_colour, read_col, read_row,
                   input ready);
   modport sink   (input valid, opcode, char_code, fg_colour, bg_colour, read_col, read_row,
                   output ready);
endinterface

@@ sv/tcw_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console response channel
// Valid/ready channel carrying one result item per console operation.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tcw_pkg::COL_W-1:0]         cursor_col;
   logic [tcw_pkg::ROW_W-1:0]         cursor_row;
   logic [tcw_pkg::CHAR_W-1:0]        cell_char;
   logic [tcw_pkg::CHAR_W-1:0]        cell_attr;
   logic                              scrolled;

   modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                   output ready);
endinterface

@@ sv/text_console_writer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Screen store of ROWS x COLS cells plus a cursor, driven by a small sequencer
// that shares one memory write port and one read port for every operation.
// ----------------------------------------------------------------------------
// Sequence: a plain write steps through decode, put and done; newline, return,
//   read and no-op items step through decode and done. No new item is taken
//   until the result loads; a result left waiting holds the block in its done state.
// A scroll adds a copy pass that moves rows up, a drain step and a blank pass
//   over the bottom row; a clear adds a blank pass over the whole store.
// Reset: cursor homes, then a pass blanks the store first.
// ----------------------------------------------------------------------------
module text_console_writer_top (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_if,
   tcw_rsp_if.source  rsp_if
);

   localparam logic [tcw_pkg::ADDR_W-1:0] ADDR_LAST  = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
   localparam logic [tcw_pkg::ADDR_W-1:0] ADDR_COLS  = tcw_pkg::ADDR_W'(tcw_pkg::COLS);
   localparam logic [tcw_pkg::ADDR_W-1:0] ADDR_BOT   =
      tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
   localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST   = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0]  ROW_PEND   = tcw_pkg::ROW_W'(tcw_pkg::ROWS);

   // ------------------------------------------------------------------------
   // Sequencer and datapath registers
   // ------------------------------------------------------------------------
   tcw_pkg::state_type state_ff, state_in;

   logic [tcw_pkg::COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [tcw_pkg::ADDR_W-1:0]  ptr_ff, ptr_in;        // sweep / copy source pointer
   logic                        cp_valid_ff, cp_valid_in;
   logic [tcw_pkg::ADDR_W-1:0]  cp_dst_ff, cp_dst_in;  // copy destination, one behind
   logic                        scrolled_ff, scrolled_in;
   logic                        put_pend_ff, put_pend_in; // write still due after scroll

   // Latched request item
   logic [tcw_pkg::OP_W-1:0]    op_ff;
   logic [tcw_pkg::CHAR_W-1:0]  ch_ff;
   logic [tcw_pkg::CHAR_W-1:0]  attr_ff;
   logic                        rd_ok_ff;
   logic [tcw_pkg::ADDR_W-1:0]  rd_addr_ff;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::COL_W-1:0]   rsp_col_ff;
   logic [tcw_pkg::ROW_W-1:0]   rsp_row_ff;
   logic [tcw_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic [tcw_pkg::CHAR_W-1:0]  rsp_attr_ff;
   logic                        rsp_scr_ff;

   // Screen store
   logic [tcw_pkg::CELL_W-1:0]  mem_ff [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0]  rdata_ff;

   logic                        wr_en;
   logic [tcw_pkg::ADDR_W-1:0]  wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  wr_data;
   logic [tcw_pkg::ADDR_W-1:0]  rd_addr;

   // ------------------------------------------------------------------------
   // Shared conditions
   // ------------------------------------------------------------------------
   logic req_take;
   logic rsp_load;
   logic is_newline;
   logic is_return;
   logic at_pending;     // newline left the cursor below the last row
   logic put_wraps;      // cursor sits on the final cell of the screen
   logic ptr_last;
   logic [tcw_pkg::ADDR_W-1:0] cur_addr;

   assign req_if.ready = (state_ff == tcw_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == tcw_pkg::ST_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign is_newline   = (ch_ff == tcw_pkg::CH_NEWLINE);
   assign is_return    = (ch_ff == tcw_pkg::CH_RETURN);
   assign at_pending   = (cur_row_ff == ROW_PEND);
   assign put_wraps    = (cur_col_ff == COL_LAST) && (cur_row_ff == ROW_LAST);
   assign ptr_last     = (ptr_ff == ADDR_LAST);

   // Linear cell address of the cursor: row * COLS + col
   assign cur_addr = tcw_pkg::ADDR_W'(cur_row_ff) * ADDR_COLS + tcw_pkg::ADDR_W'(cur_col_ff);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (ptr_last) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (req_take) state_in = tcw_pkg::ST_DECODE;
         end
         tcw_pkg::ST_DECODE: begin
            case (op_ff)
               tcw_pkg::OP_WRITE: begin
                  if (is_newline || is_return) state_in = tcw_pkg::ST_DONE;
                  else if (at_pending)         state_in = tcw_pkg::ST_COPY;
                  else                         state_in = tcw_pkg::ST_PUT;
               end
               tcw_pkg::OP_CLEAR: state_in = tcw_pkg::ST_BLANK;
               default:           state_in = tcw_pkg::ST_DONE;
            endcase
         end
         tcw_pkg::ST_PUT: begin
            state_in = put_wraps ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_COPY: begin
            if (ptr_last) state_in = tcw_pkg::ST_DRAIN;
         end
         tcw_pkg::ST_DRAIN: begin
            state_in = tcw_pkg::ST_BLANK;
         end
         tcw_pkg::ST_BLANK: begin
            if (ptr_last) state_in = put_pend_ff ? tcw_pkg::ST_PUT : tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            if (rsp_load) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_INIT;
      endcase
   end

   // ------------------------------------------------------------------------
   // Cursor, pointer and flag updates
   // ------------------------------------------------------------------------
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      ptr_in      = ptr_ff;
      scrolled_in = scrolled_ff;
      put_pend_in = put_pend_ff;
      cp_valid_in = (state_ff == tcw_pkg::ST_COPY);
      cp_dst_in   = ptr_ff - ADDR_COLS;

      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (!ptr_last) ptr_in = ptr_ff + 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            // Start every item with clean flags
            if (req_take) begin
               scrolled_in = 1'b0;
               put_pend_in = 1'b0;
            end
         end
         tcw_pkg::ST_DECODE: begin
            case (op_ff)
               tcw_pkg::OP_WRITE: begin
                  if (is_newline) begin
                     // Saturate at the pending row; no scroll until a printable byte
                     if (!at_pending) cur_row_in = cur_row_ff + 1'b1;
                     cur_col_in = '0;
                  end else if (is_return) begin
                     cur_col_in = '0;
                  end else if (at_pending) begin
                     // Scroll first, then come back for the write
                     cur_col_in  = '0;
                     cur_row_in  = ROW_LAST;
                     scrolled_in = 1'b1;
                     put_pend_in = 1'b1;
                     ptr_in      = ADDR_COLS;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  ptr_in     = '0;
               end
               default: begin
               end
            endcase
         end
         tcw_pkg::ST_PUT: begin
            put_pend_in = 1'b0;
            if (put_wraps) begin
               // Final cell written: scroll at once
               cur_col_in  = '0;
               cur_row_in  = ROW_LAST;
               scrolled_in = 1'b1;
               ptr_in      = ADDR_COLS;
            end else if (cur_col_ff == COL_LAST) begin
               cur_col_in = '0;
               cur_row_in = cur_row_ff + 1'b1;
            end else begin
               cur_col_in = cur_col_ff + 1'b1;
            end
         end
         tcw_pkg::ST_COPY: begin
            if (!ptr_last) ptr_in = ptr_ff + 1'b1;
         end
         tcw_pkg::ST_DRAIN: begin
            ptr_in = ADDR_BOT;
         end
         tcw_pkg::ST_BLANK: begin
            if (!ptr_last) ptr_in = ptr_ff + 1'b1;
         end
         tcw_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Store port selection
   // ------------------------------------------------------------------------
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = tcw_pkg::BLANK_CELL;
      unique case (state_ff)
         tcw_pkg::ST_INIT, tcw_pkg::ST_BLANK: begin
            wr_en = 1'b1;
         end
         tcw_pkg::ST_COPY, tcw_pkg::ST_DRAIN: begin
            // Move the cell read last cycle one row up
            wr_en   = cp_valid_ff;
            wr_addr = cp_dst_ff;
            wr_data = rdata_ff;
         end
         tcw_pkg::ST_PUT: begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {attr_ff, ch_ff};
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = (state_ff == tcw_pkg::ST_COPY) ? ptr_ff : rd_addr_ff;

   // Screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rdata_ff <= mem_ff[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Result register: hold until taken, reload only when free or draining
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)          rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff <= cur_col_ff;
         rsp_row_ff <= cur_row_ff;
         rsp_scr_ff <= scrolled_ff;
         if ((op_ff == tcw_pkg::OP_READ) && rd_ok_ff) begin
            rsp_char_ff <= rdata_ff[tcw_pkg::CHAR_W-1:0];
            rsp_attr_ff <= rdata_ff[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
         end else begin
            rsp_char_ff <= '0;
            rsp_attr_ff <= '0;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_col = rsp_col_ff;
   assign rsp_if.cursor_row = rsp_row_ff;
   assign rsp_if.cell_char  = rsp_char_ff;
   assign rsp_if.cell_attr  = rsp_attr_ff;
   assign rsp_if.scrolled   = rsp_scr_ff;

   // ------------------------------------------------------------------------
   // Latch the accepted item
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= req_if.opcode;
         ch_ff      <= req_if.char_code;
         attr_ff    <= {req_if.bg_colour, req_if.fg_colour};
         rd_ok_ff   <= (req_if.read_col < tcw_pkg::COL_W'(tcw_pkg::COLS)) &&
                       (req_if.read_row < ROW_PEND);
         rd_addr_ff <= tcw_pkg::ADDR_W'(req_if.read_row) * ADDR_COLS +
                       tcw_pkg::ADDR_W'(req_if.read_col);
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         ptr_ff       <= '0;
         cp_valid_ff  <= 1'b0;
         scrolled_ff  <= 1'b0;
         put_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         ptr_ff       <= ptr_in;
         cp_valid_ff  <= cp_valid_in;
         scrolled_ff  <= scrolled_in;
         put_pend_ff  <= put_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_dst_ff <= cp_dst_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTH
   // Cursor never leaves the screen, except the pending row with column zero
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cur_col_ff <= COL_LAST) && (cur_row_ff <= ROW_PEND) &&
      ((cur_row_ff != ROW_PEND) || (cur_col_ff == '0)))
      else $error("cursor out of range");

   // A character write always lands on a visible row
   a_put_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_PUT) |-> (cur_row_ff <= ROW_LAST))
      else $error("character write below last row");

   // Row copy only happens as part of a scroll, with the cursor on the last row
   a_copy_scroll: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_COPY) |-> (scrolled_ff && (cur_row_ff == ROW_LAST)))
      else $error("row copy outside a scroll");

   // Copy writes stay above the bottom row
   a_copy_dst: assert property (@(posedge clock) disable iff (reset)
      (wr_en && ((state_ff == tcw_pkg::ST_COPY) || (state_ff == tcw_pkg::ST_DRAIN)))
      |-> (wr_addr < ADDR_BOT))
      else $error("copy destination in bottom row");
`endif

endmodule

@@ test/text_console_writer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console operations through the request channel and checks every
// response against a cycle-free model of the screen store and the cursor.
// A short directed table runs first, then random write, newline, read, clear
// and noise sequences with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;

   // Opcode value that the block decodes as a no-op
   localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [tcw_pkg::OP_W-1:0] OP_WR     = tcw_pkg::OP_WRITE;
   localparam logic [tcw_pkg::OP_W-1:0] OP_CL     = tcw_pkg::OP_CLEAR;
   localparam logic [tcw_pkg::OP_W-1:0] OP_RD     = tcw_pkg::OP_READ;

   // Character codes as plain integers for the stimulus helpers
   localparam int CHAR_NL    = int'(tcw_pkg::CH_NEWLINE);
   localparam int CHAR_CR    = int'(tcw_pkg::CH_RETURN);
   localparam int SPACE_CODE = int'(tcw_pkg::CH_SPACE);

   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS  = 900;
   localparam int HOLD_OFF_AT   = 300;   // responses seen before the long stall
   localparam int HOLD_OFF_LEN  = 400;   // cycles of the long stall

   typedef struct packed {
      logic [tcw_pkg::OP_W-1:0]    opcode;
      logic [tcw_pkg::CHAR_W-1:0]  char_code;
      logic [tcw_pkg::COLOR_W-1:0] fg_colour;
      logic [tcw_pkg::COLOR_W-1:0] bg_colour;
      logic [tcw_pkg::COL_W-1:0]   read_col;
      logic [tcw_pkg::ROW_W-1:0]   read_row;
   } console_req_type;

   typedef struct packed {
      logic [tcw_pkg::COL_W-1:0]  cursor_col;
      logic [tcw_pkg::ROW_W-1:0]  cursor_row;
      logic [tcw_pkg::CHAR_W-1:0] cell_char;
      logic [tcw_pkg::CHAR_W-1:0] cell_attr;
      logic                       scrolled;
   } console_rsp_type;

   // One stimulus row: when typed_in is set, rsp holds the expected response
   typedef struct packed {
      logic            typed_in;
      console_req_type rq;
      console_rsp_type rsp;
   } stim_entry_type;

   localparam console_rsp_type FROM_MODEL = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Screen model: shadow store, cursor and the operation they go through
   // -------------------------------------------------------------------------
   logic [tcw_pkg::CELL_W-1:0] shadow_cells [tcw_pkg::CELLS];
   int                         shadow_col;
   int                         shadow_row;

   function automatic void blank_screen();
      for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
      shadow_col = 0;
      shadow_row = 0;
   endfunction

   // Scroll up one row if the cursor sits on the pending row past the bottom
   function automatic bit roll_screen_up();
      if (shadow_row < tcw_pkg::ROWS) return 1'b0;
      for (int i = 0; i + tcw_pkg::COLS < tcw_pkg::CELLS; i++)
         shadow_cells[i] = shadow_cells[i + tcw_pkg::COLS];
      for (int c = 0; c < tcw_pkg::COLS; c++)
         shadow_cells[(tcw_pkg::ROWS - 1) * tcw_pkg::COLS + c] = tcw_pkg::BLANK_CELL;
      shadow_col = 0;
      shadow_row = tcw_pkg::ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_rsp_type apply_console_op(console_req_type rq);
      console_rsp_type r;
      int              pos;
      r = '0;
      case (rq.opcode)
         tcw_pkg::OP_WRITE: begin
            if (rq.char_code == tcw_pkg::CH_NEWLINE) begin
               // saturate on the pending row; the scroll waits for a glyph
               if (shadow_row < tcw_pkg::ROWS) shadow_row++;
               shadow_col = 0;
            end else if (rq.char_code == tcw_pkg::CH_RETURN) begin
               shadow_col = 0;
            end else begin
               if (roll_screen_up()) r.scrolled = 1'b1;
               pos = shadow_row * tcw_pkg::COLS + shadow_col;
               if (pos < tcw_pkg::CELLS)
                  shadow_cells[pos] = {rq.bg_colour, rq.fg_colour, rq.char_code};
               pos++;
               shadow_row = pos / tcw_pkg::COLS;
               shadow_col = pos % tcw_pkg::COLS;
               if (shadow_row > tcw_pkg::ROWS) shadow_row = tcw_pkg::ROWS;
               // writing the final cell scrolls at once
               if (roll_screen_up()) r.scrolled = 1'b1;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            blank_screen();
         end
         tcw_pkg::OP_READ: begin
            if (rq.read_col < tcw_pkg::COLS && rq.read_row < tcw_pkg::ROWS) begin
               {r.cell_attr, r.cell_char} =
                  shadow_cells[rq.read_row * tcw_pkg::COLS + rq.read_col];
            end
         end
         default: ;
      endcase
      r.cursor_col = shadow_col[tcw_pkg::COL_W-1:0];
      r.cursor_row = shadow_row[tcw_pkg::ROW_W-1:0];
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------
   stim_entry_type directed_tbl [DIRECTED_ROWS];
   stim_entry_type stim_q [$];
   int             random_count;

   function automatic console_req_type mk_req(logic [tcw_pkg::OP_W-1:0] op, int ch,
                                              int fg, int bg, int col, int row);
      console_req_type r;
      r.opcode    = op;
      r.char_code = tcw_pkg::CHAR_W'(ch);
      r.fg_colour = tcw_pkg::COLOR_W'(fg);
      r.bg_colour = tcw_pkg::COLOR_W'(bg);
      r.read_col  = tcw_pkg::COL_W'(col);
      r.read_row  = tcw_pkg::ROW_W'(row);
      return r;
   endfunction

   function automatic console_rsp_type mk_rsp(int col, int row, int ch, int attr, int scr);
      console_rsp_type r;
      r.cursor_col = tcw_pkg::COL_W'(col);
      r.cursor_row = tcw_pkg::ROW_W'(row);
      r.cell_char  = tcw_pkg::CHAR_W'(ch);
      r.cell_attr  = tcw_pkg::CHAR_W'(attr);
      r.scrolled   = (scr != 0);
      return r;
   endfunction

   // Queue one item for the model to predict; no-ops do not count as work
   function automatic void push_item(console_req_type rq);
      stim_q.push_back({1'b0, rq, FROM_MODEL});
      if (rq.opcode != OP_UNUSED) random_count++;
   endfunction

   // Any byte but newline and carriage return
   function automatic int random_glyph();
      int ch;
      do ch = $urandom_range(0, 255);
      while (ch == CHAR_NL || ch == CHAR_CR);
      return ch;
   endfunction

   function automatic void push_glyphs(int n);
      for (int i = 0; i < n; i++) begin
         push_item(mk_req(OP_WR, random_glyph(), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 31)));
      end
   endfunction

   function automatic void push_newlines(int n);
      for (int i = 0; i < n; i++) begin
         push_item(mk_req(OP_WR, CHAR_NL, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 127), $urandom_range(0, 31)));
      end
   endfunction

   // Push the cursor onto the pending row, saturate it, then fill the bottom
   // line so that the last glyph lands on the final cell and scrolls at once.
   function automatic void push_fill_bottom();
      push_newlines(tcw_pkg::ROWS + 1);
      push_glyphs(tcw_pkg::COLS);
      push_item(mk_req(OP_RD, 0, 0, 0, $urandom_range(0, tcw_pkg::COLS - 1),
                       tcw_pkg::ROWS - 2));
      push_item(mk_req(OP_RD, 0, 0, 0, tcw_pkg::COLS - 1, tcw_pkg::ROWS - 1));
   endfunction

   function automatic void build_random_part();
      int kind;
      int n;
      random_count = 0;
      push_fill_bottom();
      while (random_count < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // a line of text, usually ended by newline or return
            push_glyphs($urandom_range(1, 100));
            n = $urandom_range(0, 99);
            if (n < 50) push_newlines(1);
            else if (n < 65) push_item(mk_req(OP_WR, CHAR_CR, $urandom_range(0, 15),
                                              $urandom_range(0, 15), 0, 0));
         end else if (kind < 50) begin
            push_newlines($urandom_range(1, 30));
         end else if (kind < 65) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 4) != 0)
                  push_item(mk_req(OP_RD, $urandom_range(0, 255), $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom_range(0, tcw_pkg::COLS - 1),
                                   $urandom_range(0, tcw_pkg::ROWS - 1)));
               else
                  push_item(mk_req(OP_RD, $urandom_range(0, 255), $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom_range(0, 127),
                                   $urandom_range(0, 31)));
            end
         end else if (kind < 69) begin
            push_fill_bottom();
         end else if (kind < 72) begin
            push_item(mk_req(OP_CL, $urandom_range(0, 255), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom_range(0, 127),
                             $urandom_range(0, 31)));
         end else begin
            // noise: every field random, the unused opcode included
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               push_item(mk_req(tcw_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                                $urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 127), $urandom_range(0, 31)));
            end
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps
   // -------------------------------------------------------------------------
   int send_idx   = 0;
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      stim_entry_type ent;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.opcode    <= tcw_pkg::OP_WRITE;
         req_ch.char_code <= '0;
         req_ch.fg_colour <= '0;
         req_ch.bg_colour <= '0;
         req_ch.read_col  <= '0;
         req_ch.read_row  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // the previous item, if any, was taken at this edge: offer the next
         if (gap_left > 0 || send_idx >= stim_q.size()) begin
            req_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            ent = stim_q[send_idx];
            req_ch.valid     <= 1'b1;
            req_ch.opcode    <= ent.rq.opcode;
            req_ch.char_code <= ent.rq.char_code;
            req_ch.fg_colour <= ent.rq.fg_colour;
            req_ch.bg_colour <= ent.rq.bg_colour;
            req_ch.read_col  <= ent.rq.read_col;
            req_ch.read_row  <= ent.rq.read_row;
            send_idx++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // a quarter of the bursts run straight into the next one
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: its own stall pattern, plus one long hold-off that backs the
   // block up until it refuses new items
   // -------------------------------------------------------------------------
   int n_accepted = 0;
   int n_checked  = 0;
   int stall_mode = 0;
   int mode_left  = 0;
   int rx_tick    = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && n_checked >= HOLD_OFF_AT) begin
         rsp_ch.ready <= 1'b0;
         hold_left = HOLD_OFF_LEN - 1;
         hold_done = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ch.ready <= (rx_tick % 4 != 0);
         endcase
         rx_tick++;
      end
   end

   // -------------------------------------------------------------------------
   // Checker: predict on every accepted item, compare every accepted response
   // -------------------------------------------------------------------------
   console_rsp_type reports_due [$];
   int              errors = 0;

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      console_rsp_type want;
      console_rsp_type modeled;
      console_req_type seen;
      if (!reset) begin
         // drain first: a response can never belong to an item taken this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reports_due.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected response, expected none, actual col %0d row %0d",
                        $time, rsp_ch.cursor_col, rsp_ch.cursor_row);
            end else begin
               want = reports_due.pop_front();
               check_field("cursor_col", int'(want.cursor_col), int'(rsp_ch.cursor_col));
               check_field("cursor_row", int'(want.cursor_row), int'(rsp_ch.cursor_row));
               check_field("cell_char",  int'(want.cell_char),  int'(rsp_ch.cell_char));
               check_field("cell_attr",  int'(want.cell_attr),  int'(rsp_ch.cell_attr));
               check_field("scrolled",   int'(want.scrolled),   int'(rsp_ch.scrolled));
            end
            n_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.opcode    = req_ch.opcode;
            seen.char_code = req_ch.char_code;
            seen.fg_colour = req_ch.fg_colour;
            seen.bg_colour = req_ch.bg_colour;
            seen.read_col  = req_ch.read_col;
            seen.read_row  = req_ch.read_row;
            // advance the model always; a typed row overrides its prediction
            modeled = apply_console_op(seen);
            if (n_accepted < DIRECTED_ROWS && stim_q[n_accepted].typed_in)
               reports_due.push_back(stim_q[n_accepted].rsp);
            else
               reports_due.push_back(modeled);
            n_accepted++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      blank_screen();

      // Directed rows. The cursor starts home on a blank screen; reads past
      // either edge and the unused opcode return zero cell fields.
      directed_tbl = '{
         {1'b1, mk_req(OP_RD,     0,       0,  0,  0,   0),  mk_rsp(0, 0, SPACE_CODE, 0, 0)},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  79,  24), mk_rsp(0, 0, SPACE_CODE, 0, 0)},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  80,  0),  mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  0,   25), mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_RD,     255,     15, 15, 127, 31), mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_UNUSED, 255,     15, 15, 127, 31), mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_WR,     255,     15, 15, 127, 31), mk_rsp(1, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_WR,     0,       0,  0,  0,   0),  mk_rsp(2, 0, 0, 0, 0)},
         {1'b0, mk_req(OP_WR,     'h41,    5,  10, 0,   0),  FROM_MODEL},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  0,   0),  mk_rsp(3, 0, 255, 255, 0)},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  1,   0),  mk_rsp(3, 0, 0, 0, 0)},
         {1'b0, mk_req(OP_RD,     0,       0,  0,  2,   0),  FROM_MODEL},
         {1'b1, mk_req(OP_WR,     CHAR_CR, 7,  3,  0,   0),  mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_WR,     CHAR_NL, 15, 15, 0,   0),  mk_rsp(0, 1, 0, 0, 0)},
         {1'b0, mk_req(OP_WR,     'h7A,    1,  2,  0,   0),  FROM_MODEL},
         {1'b0, mk_req(OP_WR,  SPACE_CODE, 15, 0,  0,   0),  FROM_MODEL},
         {1'b1, mk_req(OP_CL,     'h51,    9,  6,  12,  3),  mk_rsp(0, 0, 0, 0, 0)},
         {1'b1, mk_req(OP_RD,     0,       0,  0,  0,   1),  mk_rsp(0, 0, SPACE_CODE, 0, 0)},
         {1'b0, mk_req(OP_WR,     'h80,    0,  15, 0,   0),  FROM_MODEL},
         {1'b0, mk_req(OP_RD,     0,       0,  0,  0,   0),  FROM_MODEL},
         {1'b1, mk_req(OP_CL,     0,       0,  0,  0,   0),  mk_rsp(0, 0, 0, 0, 0)}
      };
      for (int i = 0; i < DIRECTED_ROWS; i++) stim_q.push_back(directed_tbl[i]);
      build_random_part();

      // synchronous reset; the block then blanks its store before taking items
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // advance until every item is taken and every response has come back
      while (n_accepted < stim_q.size() || reports_due.size() != 0) @(posedge clock);
      // keep the clock running afterwards to catch any stray response
      repeat (50) @(posedge clock);

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: every item scrolling, with the longest gaps and stalls, still
   // ends well inside this bound
   initial begin
      #60_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ text_console_writer_top.f @@
sv/tcw_pkg.sv
sv/tcw_req_if.sv
sv/tcw_rsp_if.sv
sv/text_console_writer_top.sv
test/text_console_writer_top_tb.sv
